// File: rtl/core/set_associative_lru_cache_model_top_macros.svh
// Assertion macros for the cache model checker.
`ifndef SET_ASSOCIATIVE_LRU_CACHE_MODEL_TOP_MACROS_SVH
`define SET_ASSOCIATIVE_LRU_CACHE_MODEL_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SALC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SALC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/salc_pkg.sv
// Shared constants and codes for the set-associative LRU cache model.
package salc_pkg;

    localparam int ADDR_W = 64;
    localparam int TAG_W  = 64;
    localparam int CNT_W  = 32;
    localparam int OP_W   = 2;
    localparam int HITS_W = 2;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // access kinds
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_SET_BITS    = 2'd0;
    localparam logic [1:0] REG_WAYS_IN_USE = 2'd1;
    localparam logic [1:0] REG_OFFSET_BITS = 2'd2;

    localparam logic [3:0] SET_BITS_RST    = 4'd4;
    localparam logic [3:0] WAYS_IN_USE_RST = 4'd1;
    localparam logic [5:0] OFFSET_BITS_RST = 6'd4;

endpackage

// File: rtl/core/set_associative_lru_cache_model_top.sv
// One access at a time: a request is taken only while idle; the set row is read from the
// line memory at transfer, then compare, LRU update and write-back of the same row follow
// in the lookup state, which waits while an earlier result is unaccepted; the result is registered.
// Reset: async active low; counters cleared, configuration registers set to reset values,
// then a clearing pass writes every set row before the first request is taken.
module set_associative_lru_cache_model_top #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [salc_pkg::OP_W-1:0]     operation,
    input  logic [salc_pkg::ADDR_W-1:0]   address,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic                          miss,
    output logic                          eviction,
    output logic [salc_pkg::HITS_W-1:0]   hits,
    output logic [salc_pkg::CNT_W-1:0]    total_hits,
    output logic [salc_pkg::CNT_W-1:0]    total_misses,
    output logic [salc_pkg::CNT_W-1:0]    total_evictions,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [salc_pkg::PADDR_W-1:0]  paddr,
    input  logic [salc_pkg::PDATA_W-1:0]  pwdata,
    output logic [salc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int SETW     = MAX_SET_BITS;
    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int RW       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam logic [RW-1:0] RANK_MAX = RW'(MAX_WAYS - 1);

    typedef struct packed {
        logic                         vld;
        logic [salc_pkg::TAG_W-1:0]   tag;
        logic [RW-1:0]                rank;
    } line_t;

    typedef line_t [MAX_WAYS-1:0] row_t;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOOK  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [3:0] set_bits_reg;
    logic [3:0] ways_reg;
    logic [5:0] offset_reg;

    logic [SETW-1:0] clr_cnt_reg;
    logic [SETW-1:0] set_reg;
    logic [salc_pkg::TAG_W-1:0] tag_reg;
    logic [salc_pkg::OP_W-1:0]  op_reg;

    row_t mem [NUM_SETS];
    row_t rd_row_reg;

    logic                           rsp_valid_reg;
    logic                           miss_reg;
    logic                           eviction_reg;
    logic [salc_pkg::HITS_W-1:0]    hits_reg;
    logic [salc_pkg::CNT_W-1:0]     total_hits_reg;
    logic [salc_pkg::CNT_W-1:0]     total_misses_reg;
    logic [salc_pkg::CNT_W-1:0]     total_evictions_reg;
    logic [salc_pkg::CNT_W-1:0]     hit_cnt_reg, hit_cnt_next;
    logic [salc_pkg::CNT_W-1:0]     miss_cnt_reg, miss_cnt_next;
    logic [salc_pkg::CNT_W-1:0]     evict_cnt_reg, evict_cnt_next;

    logic [4:0]  sb_raw, sb_eff;
    logic [5:0]  ways_raw, ways_eff;
    logic [5:0]  ob_eff;
    logic [6:0]  tag_shift;
    logic [salc_pkg::ADDR_W-1:0] addr_shifted;
    logic [SETW-1:0] set_mask, set_next;
    logic [salc_pkg::TAG_W-1:0] tag_next;

    logic req_fire, look_go, cfg_wr;

    logic            hit_found, free_found;
    logic [RW-1:0]   hit_way, free_way, vic_way, tgt_way;
    logic [RW-1:0]   vic_rank, old_rank;
    logic            age_all;
    logic [MAX_WAYS-1:0] used;
    row_t            wr_row;
    logic [salc_pkg::HITS_W-1:0] hits_next;
    logic [salc_pkg::CNT_W:0]    hit_sum;

    logic            mem_we;
    logic [SETW-1:0] mem_waddr;
    row_t            mem_wdata;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg <= salc_pkg::SET_BITS_RST;
            ways_reg     <= salc_pkg::WAYS_IN_USE_RST;
            offset_reg   <= salc_pkg::OFFSET_BITS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                salc_pkg::REG_SET_BITS:    set_bits_reg <= pwdata[3:0];
                salc_pkg::REG_WAYS_IN_USE: ways_reg     <= pwdata[3:0];
                salc_pkg::REG_OFFSET_BITS: offset_reg   <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            salc_pkg::REG_SET_BITS:    prdata = {28'd0, set_bits_reg};
            salc_pkg::REG_WAYS_IN_USE: prdata = {28'd0, ways_reg};
            salc_pkg::REG_OFFSET_BITS: prdata = {26'd0, offset_reg};
            default:                   prdata = '0;
        endcase
    end

    // ---------------- address split ----------------
    always_comb
    begin
        sb_raw = {1'b0, set_bits_reg};
        if (sb_raw == 5'd0)
            sb_eff = 5'd1;
        else if (sb_raw > 5'(MAX_SET_BITS))
            sb_eff = 5'(MAX_SET_BITS);
        else
            sb_eff = sb_raw;

        ways_raw = {2'b00, ways_reg};
        if (ways_raw == 6'd0)
            ways_eff = 6'd1;
        else if (ways_raw > 6'(MAX_WAYS))
            ways_eff = 6'(MAX_WAYS);
        else
            ways_eff = ways_raw;

        if (offset_reg == 6'd0)
            ob_eff = 6'd1;
        else if (offset_reg > 6'd32)
            ob_eff = 6'd32;
        else
            ob_eff = offset_reg;

        addr_shifted = address >> ob_eff;
        set_mask     = ~({SETW{1'b1}} << sb_eff);
        set_next     = addr_shifted[SETW-1:0] & set_mask;
        tag_shift    = 7'(ob_eff) + 7'(sb_eff);
        tag_next     = address >> tag_shift;
    end

    // ---------------- control ----------------
    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid & req_ready;
    assign look_go   = (state_reg == ST_LOOK) & (~rsp_valid_reg | rsp_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == {SETW{1'b1}}) state_next = ST_IDLE;
            ST_IDLE:  if (req_fire) state_next = ST_LOOK;
            ST_LOOK:  if (look_go) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (look_go)
            begin
                rsp_valid_reg <= 1'b1;
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                evict_cnt_reg <= evict_cnt_next;
            end
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // request fields captured at transfer
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            set_reg <= set_next;
            tag_reg <= tag_next;
            op_reg  <= operation;
        end
    end

    // ---------------- line memory, one row per set ----------------
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = set_reg;
        mem_wdata = wr_row;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (look_go)
            mem_we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (req_fire)
            rd_row_reg <= mem[set_next];
    end

    // ---------------- lookup, victim choice and LRU update ----------------
    always_comb
    begin
        hit_found  = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            used[i] = (6'(i) < ways_eff);
            if (!hit_found && used[i] && rd_row_reg[i].vld && rd_row_reg[i].tag == tag_reg)
            begin
                hit_found = 1'b1;
                hit_way   = RW'(i);
            end
            if (!free_found && used[i] && !rd_row_reg[i].vld)
            begin
                free_found = 1'b1;
                free_way   = RW'(i);
            end
        end

        // oldest used way, lowest index on a tie
        vic_way  = '0;
        vic_rank = rd_row_reg[0].rank;
        for (int i = 1; i < MAX_WAYS; i++)
        begin
            if (used[i] && rd_row_reg[i].rank > vic_rank)
            begin
                vic_way  = RW'(i);
                vic_rank = rd_row_reg[i].rank;
            end
        end

        if (hit_found)
        begin
            tgt_way  = hit_way;
            old_rank = rd_row_reg[hit_way].rank;
            age_all  = 1'b0;
        end
        else if (free_found)
        begin
            tgt_way  = free_way;
            old_rank = '0;
            age_all  = 1'b1;  // a filled empty line is older than every valid one
        end
        else
        begin
            tgt_way  = vic_way;
            old_rank = vic_rank;
            age_all  = 1'b0;
        end

        wr_row = rd_row_reg;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (used[i] && RW'(i) != tgt_way && rd_row_reg[i].vld
                && (age_all || rd_row_reg[i].rank < old_rank)
                && rd_row_reg[i].rank != RANK_MAX)
                wr_row[i].rank = rd_row_reg[i].rank + 1'b1;
        end
        wr_row[tgt_way].rank = '0;
        wr_row[tgt_way].vld  = 1'b1;
        if (!hit_found)
            wr_row[tgt_way].tag = tag_reg;

        hits_next = {1'b0, hit_found} + {1'b0, op_reg == salc_pkg::OP_MODIFY};

        hit_sum = {1'b0, hit_cnt_reg} + (salc_pkg::CNT_W + 1)'(hits_next);
        hit_cnt_next = hit_sum[salc_pkg::CNT_W] ? salc_pkg::CNT_MAX
                                                : hit_sum[salc_pkg::CNT_W-1:0];

        miss_cnt_next = miss_cnt_reg;
        if (!hit_found && miss_cnt_reg != salc_pkg::CNT_MAX)
            miss_cnt_next = miss_cnt_reg + 1'b1;

        evict_cnt_next = evict_cnt_reg;
        if (!hit_found && !free_found && evict_cnt_reg != salc_pkg::CNT_MAX)
            evict_cnt_next = evict_cnt_reg + 1'b1;
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk)
    begin
        if (look_go)
        begin
            miss_reg            <= ~hit_found;
            eviction_reg        <= ~hit_found & ~free_found;
            hits_reg            <= hits_next;
            total_hits_reg      <= hit_cnt_next;
            total_misses_reg    <= miss_cnt_next;
            total_evictions_reg <= evict_cnt_next;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign miss            = miss_reg;
    assign eviction        = eviction_reg;
    assign hits            = hits_reg;
    assign total_hits      = total_hits_reg;
    assign total_misses    = total_misses_reg;
    assign total_evictions = total_evictions_reg;

endmodule

// File: rtl/core/salc_checker.sv
// Port-level checker for the cache model, bound to the top level.
`include "set_associative_lru_cache_model_top_macros.svh"

module salc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        miss,
    input logic                        eviction,
    input logic [salc_pkg::HITS_W-1:0] hits,
    input logic [salc_pkg::CNT_W-1:0]  total_hits,
    input logic [salc_pkg::CNT_W-1:0]  total_misses,
    input logic [salc_pkg::CNT_W-1:0]  total_evictions
);

    // an eviction only comes with a miss
    `SALC_ASSERT_IMP(a_evict_needs_miss, rsp_valid, !eviction || miss, "eviction without miss")

    // every access either misses or hits
    `SALC_ASSERT_IMP(a_hit_or_miss, rsp_valid, miss || hits != 2'd0, "neither hit nor miss")

    // an access taken with the result slot empty shows its result after the lookup state, with no stall
    `SALC_ASSERT_IMP(a_latency, req_valid && req_ready && !rsp_valid, ##2 rsp_valid,
        "result late")

    // running totals never go down from one result to the next view
    `SALC_ASSERT_NXT(a_totals_mono, rsp_valid && rsp_ready,
        total_hits >= $past(total_hits) && total_misses >= $past(total_misses)
        && total_evictions >= $past(total_evictions), "total decreased")

endmodule

bind set_associative_lru_cache_model_top salc_checker u_salc_checker (.*);

// File: tb/lru_cache_result_check.sv
// Result checker for the LRU cache model: predicts each access and compares every transfer.
module lru_cache_result_check
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  logic [OP_W-1:0]     operation,
    input  logic [ADDR_W-1:0]   address,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  logic                miss,
    input  logic                eviction,
    input  logic [HITS_W-1:0]   hits,
    input  logic [CNT_W-1:0]    total_hits,
    input  logic [CNT_W-1:0]    total_misses,
    input  logic [CNT_W-1:0]    total_evictions,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    input  logic                pready,
    output int                  fail_count,
    output int                  pending,
    output int                  compared
);

    localparam int NUM_LINES = (1 << MAX_SET_BITS) * MAX_WAYS;

    typedef struct packed {
        logic              miss;
        logic              eviction;
        logic [HITS_W-1:0] hits;
        logic [CNT_W-1:0]  hit_sum;
        logic [CNT_W-1:0]  miss_sum;
        logic [CNT_W-1:0]  evict_sum;
    } access_outcome_t;

    logic [3:0]        set_bits_r;
    logic [3:0]        ways_r;
    logic [5:0]        offset_r;

    logic              valid_bit [NUM_LINES];
    logic [TAG_W-1:0]  tag_of    [NUM_LINES];
    int                age_of    [NUM_LINES];
    logic [CNT_W-1:0]  hit_tally;
    logic [CNT_W-1:0]  miss_tally;
    logic [CNT_W-1:0]  evict_tally;

    access_outcome_t   pending_outcomes[$];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR @%0t result #%0d %s: got 0x%0h, expected 0x%0h",
                 $time, compared, what, got, want);
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Way w becomes most recent; valid ways younger than its old age grow one older.
    function automatic void make_recent(int base, int nways, int w, int old_age);
        for (int i = 0; i < nways; i++)
        begin
            if (i != w && valid_bit[base+i] && age_of[base+i] < old_age
                && age_of[base+i] < MAX_WAYS - 1)
                age_of[base+i]++;
        end
        age_of[base+w] = 0;
    endfunction

    function automatic access_outcome_t lookup_and_update(logic [OP_W-1:0] op,
                                                          logic [ADDR_W-1:0] addr);
        int              sb;
        int              nways;
        int              ob;
        int              base;
        int              found;
        int              free_way;
        int              victim;
        int              oldest;
        logic [TAG_W-1:0] tag;
        access_outcome_t r;

        sb    = (set_bits_r < 1) ? 1 : (set_bits_r > MAX_SET_BITS) ? MAX_SET_BITS
                                                                  : int'(set_bits_r);
        nways = (ways_r < 1) ? 1 : (ways_r > MAX_WAYS) ? MAX_WAYS : int'(ways_r);
        ob    = (offset_r < 1) ? 1 : (offset_r > 32) ? 32 : int'(offset_r);
        base  = int'((addr >> ob) & ((64'd1 << sb) - 64'd1)) * MAX_WAYS;
        tag   = addr >> (ob + sb);
        found    = -1;
        free_way = -1;
        r        = '0;

        for (int i = 0; i < nways; i++)
        begin
            if (valid_bit[base+i] && tag_of[base+i] == tag)
            begin
                found = i;
                break;
            end
        end

        if (found >= 0)
        begin
            r.hits = 1;
            if (hit_tally != CNT_MAX) hit_tally++;
            make_recent(base, nways, found, age_of[base+found]);
        end
        else
        begin
            r.miss = 1'b1;
            if (miss_tally != CNT_MAX) miss_tally++;
            for (int i = 0; i < nways; i++)
            begin
                if (!valid_bit[base+i])
                begin
                    free_way = i;
                    break;
                end
            end
            if (free_way >= 0)
            begin
                valid_bit[base+free_way] = 1'b1;
                tag_of[base+free_way]    = tag;
                // a fresh line counts as older than every valid one
                make_recent(base, nways, free_way, MAX_WAYS);
            end
            else
            begin
                victim = 0;
                oldest = age_of[base];
                for (int i = 1; i < nways; i++)
                begin
                    if (age_of[base+i] > oldest)
                    begin
                        oldest = age_of[base+i];
                        victim = i;
                    end
                end
                r.eviction = 1'b1;
                if (evict_tally != CNT_MAX) evict_tally++;
                tag_of[base+victim] = tag;
                make_recent(base, nways, victim, oldest);
            end
        end

        if (op == OP_MODIFY)
        begin
            r.hits = r.hits + 1'b1;
            if (hit_tally != CNT_MAX) hit_tally++;
        end

        r.hit_sum   = hit_tally;
        r.miss_sum  = miss_tally;
        r.evict_sum = evict_tally;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        access_outcome_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LINES; i++)
            begin
                valid_bit[i] = 1'b0;
                tag_of[i]    = '0;
                age_of[i]    = 0;
            end
            hit_tally   = '0;
            miss_tally  = '0;
            evict_tally = '0;
            set_bits_r  = SET_BITS_RST;
            ways_r      = WAYS_IN_USE_RST;
            offset_r    = OFFSET_BITS_RST;
            pending_outcomes.delete();
            pending    = 0;
            fail_count = 0;
            compared   = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_SET_BITS:    set_bits_r = pwdata[3:0];
                    REG_WAYS_IN_USE: ways_r     = pwdata[3:0];
                    REG_OFFSET_BITS: offset_r   = pwdata[5:0];
                    default: ;
                endcase
            end

            if (rsp_valid && rsp_ready)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    report_mismatch("transfer with nothing expected", 64'(miss), 64'd0);
                end
                else
                begin
                    e = pending_outcomes.pop_front();
                    check_field("miss", 64'(miss), 64'(e.miss));
                    check_field("eviction", 64'(eviction), 64'(e.eviction));
                    check_field("hits", 64'(hits), 64'(e.hits));
                    check_field("total_hits", 64'(total_hits), 64'(e.hit_sum));
                    check_field("total_misses", 64'(total_misses), 64'(e.miss_sum));
                    check_field("total_evictions", 64'(total_evictions), 64'(e.evict_sum));
                end
                compared++;
            end

            if (req_valid && req_ready)
                pending_outcomes.push_back(lookup_and_update(operation, address));

            pending = pending_outcomes.size();
        end
    end

endmodule

// File: tb/tb_set_associative_lru_cache_model_top.sv
// Testbench top for the LRU cache model: clock, reset, stimulus, watchdog and verdict.
module tb_set_associative_lru_cache_model_top;
    import salc_pkg::*;

    localparam int MAX_SET_BITS = 8;
    localparam int MAX_WAYS     = 8;
    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SEG_ITEMS    = 100;
    localparam int NUM_SEGS     = 8;
    localparam int HOT_N        = 16;

    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
    localparam logic [1:0]      REG_UNUSED  = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_ready;
    logic [OP_W-1:0]      operation;
    logic [ADDR_W-1:0]    address;
    logic                 rsp_valid;
    logic                 rsp_ready;
    logic                 miss;
    logic                 eviction;
    logic [HITS_W-1:0]    hits;
    logic [CNT_W-1:0]     total_hits;
    logic [CNT_W-1:0]     total_misses;
    logic [CNT_W-1:0]     total_evictions;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    int                   fail_count;
    int                   pending;
    int                   compared;

    int                   idle_pct = 0;
    int                   stall_pct = 0;
    int                   hold_reqs = 0;
    int                   holds_taken = 0;
    int                   hold_left = 0;
    int                   quiet_cycles = 0;
    int                   items_sent = 0;
    int                   cfg_writes = 0;
    int                   sb_eff = 4;
    int                   ob_eff = 4;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    set_associative_lru_cache_model_top #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS(MAX_WAYS)
    ) DUT (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready),
        .operation(operation), .address(address),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
        .miss(miss), .eviction(eviction), .hits(hits),
        .total_hits(total_hits), .total_misses(total_misses),
        .total_evictions(total_evictions),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    lru_cache_result_check #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS(MAX_WAYS)
    ) u_result_check (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready),
        .operation(operation), .address(address),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
        .miss(miss), .eviction(eviction), .hits(hits),
        .total_hits(total_hits), .total_misses(total_misses),
        .total_evictions(total_evictions),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending(pending), .compared(compared)
    );

    // Receiver side: random stalls, plus one long hold-off on request.
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_reqs != holds_taken)
            begin
                holds_taken = hold_reqs;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: any transfer on either channel or a register-port write restarts the count.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready)
            || (psel && penable && pwrite && pready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TIMEOUT: no transfer for %0d cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic int fit(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    task automatic send_access(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        operation <= op;
        address   <= addr;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop valid and wait for every outstanding result.
    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input int raw);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (PDATA_W'($urandom) << 6) | PDATA_W'(raw);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_writes++;
        if (idx == REG_SET_BITS)
            sb_eff = fit(raw & 15, 1, MAX_SET_BITS);
        else if (idx == REG_OFFSET_BITS)
            ob_eff = fit(raw & 63, 1, 32);
    endtask

    task automatic set_cache_shape(input int sb_raw, input int ways_raw, input int ob_raw);
        write_cfg(REG_SET_BITS, sb_raw);
        write_cfg(REG_WAYS_IN_USE, ways_raw);
        write_cfg(REG_OFFSET_BITS, ob_raw);
    endtask

    initial
    begin
        logic [ADDR_W-1:0] hot_addr [HOT_N];
        logic [ADDR_W-1:0] tag;
        logic [ADDR_W-1:0] addr;
        logic [OP_W-1:0]   op;
        int                hot_sets;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        operation = OP_LOAD;
        address   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Direct-mapped at reset shape: fill, hit, modify hit, conflict eviction, code 3.
        send_access(OP_LOAD, 64'h0);
        send_access(OP_LOAD, 64'h0);
        send_access(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(OP_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(OP_MODIFY, 64'h100);
        send_access(OP_RESERVED, 64'h10F);
        send_access(OP_RESERVED, 64'h0);

        // Four ways in set 0: fill the rest, refresh one, then two LRU victims.
        settle();
        write_cfg(REG_WAYS_IN_USE, 4);
        send_access(OP_STORE, 64'h100);
        send_access(OP_STORE, 64'h200);
        send_access(OP_STORE, 64'h300);
        send_access(OP_LOAD, 64'h000);
        send_access(OP_MODIFY, 64'h400);
        send_access(OP_LOAD, 64'h100);

        // Below-range values clamp to the minimum; extra ways are kept, not cleared.
        settle();
        set_cache_shape(0, 0, 0);
        write_cfg(REG_UNUSED, 9);
        send_access(OP_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
        send_access(OP_STORE, 64'h5555_5555_5555_5555);
        send_access(OP_LOAD, 64'h5555_5555_5555_5555);

        // Above-range values clamp to the maximum.
        settle();
        set_cache_shape(15, 15, 63);
        send_access(OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(OP_STORE, 64'h8000_0000_0000_0000);
        send_access(OP_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);

        for (int seg = 0; seg < NUM_SEGS; seg++)
        begin
            settle();
            case (seg)
                0: set_cache_shape(1, 8, 1);
                1: set_cache_shape(8, 1, 32);
                2: set_cache_shape(2, 8, 6);
                3: set_cache_shape(3, 2, 12);
                default: set_cache_shape($urandom_range(15), $urandom_range(15),
                                         $urandom_range(63));
            endcase
            case (seg % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 73;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 73;
                end
                default:
                begin
                    idle_pct  = 30;
                    stall_pct = 30;
                end
            endcase

            // A small working set over a few sets so hits and evictions both occur.
            hot_sets = ((1 << sb_eff) < 4) ? (1 << sb_eff) : 4;
            for (int k = 0; k < HOT_N; k++)
            begin
                tag = ($urandom_range(5) == 0) ? {$urandom, $urandom}
                                               : 64'($urandom_range(11));
                hot_addr[k] = (tag << (ob_eff + sb_eff))
                            | (64'($urandom_range(hot_sets - 1)) << ob_eff);
            end

            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                case ($urandom_range(9))
                    0:       op = OP_RESERVED;
                    1, 2, 3: op = OP_LOAD;
                    4, 5, 6: op = OP_STORE;
                    default: op = OP_MODIFY;
                endcase
                if ($urandom_range(3) != 0)
                    addr = hot_addr[$urandom_range(HOT_N - 1)]
                         | ({$urandom, $urandom} & ((64'd1 << ob_eff) - 64'd1));
                else
                    addr = {$urandom, $urandom};
                send_access(op, addr);
                // long receiver hold-off while the sender keeps offering
                if (seg == 0 && n == 20)
                    hold_reqs++;
            end
        end

        settle();
        repeat (4) @(posedge clk);
        $display("Run covered %0d accesses and %0d register writes; %0d results compared.",
                 items_sent, cfg_writes, compared);
        $display("Idle mixes: none, sender 73%%, receiver 73%%, both 30%%, one long hold-off.");
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/salc_pkg.sv
rtl/core/set_associative_lru_cache_model_top.sv
rtl/core/salc_checker.sv
tb/lru_cache_result_check.sv
tb/tb_set_associative_lru_cache_model_top.sv
